// ----- sv/eitp_pkg.sv -----
package eitp_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 16384;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ETHERTYPE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL = 8'd1;

  localparam logic [15:0] ETHERTYPE_RST = 16'h0800;
  localparam logic [7:0] PROTOCOL_RST = 8'd6;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Frame offsets of the captured fields and the header boundaries.
  localparam int MAC_DST_END = 6;
  localparam int MAC_SRC_END = 12;
  localparam int ETH_LEN = 14;
  localparam int PROTO_OFS = 23;
  localparam int IP_ADDR_OFS = 26;
  localparam int IP_END = 34;
  localparam int PORT_END = 38;
  localparam int TCP_END = 54;
  localparam int FULL_LEN = 58;
  localparam int CRC_SKIP = 4;

  localparam int STATUS_W = 3;
  localparam int PAY_W = 14;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT_ETH = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ETHERTYPE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SHORT_IP = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_PROTOCOL = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SHORT_TCP = 3'd5;

  // Everything the result stage needs about a frame that just ended.
  typedef struct packed {
    logic [47:0]      dest_mac;
    logic [47:0]      src_mac;
    logic [15:0]      ether_type;
    logic [7:0]       protocol;
    logic [63:0]      ip_pair;
    logic [31:0]      port_pair;
    logic             ge_eth;
    logic             ge_ip;
    logic             ge_tcp;
    logic             ge_full;
    logic [PAY_W-1:0] payload;
    logic             crc_equal;
  } frame_sum_t;

  // Non-reflected CRC-32, one byte, most significant bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/eth_ipv4_tcp_frame_parser.sv -----
// Ethernet / IPv4 / TCP header parser with a CRC-32 trailer check.
// Frame bytes arrive on the in_ channel in wire order, one request per byte,
// with in_end_of_frame set on the last byte. Headers are taken at fixed
// offsets (no IP options). The last byte of each frame produces exactly one
// request on the out_ channel carrying the status, captured fields, payload
// size and CRC outcome; other bytes produce nothing.
// A byte accepted into the input register is folded into the frame state
// (byte-wide CRC and header capture) when it leaves that register, and for a
// last byte its result is registered in the output register at that edge.
// Throughput is one byte per clock cycle unless a final byte waits (below).
// The cfg_ channel writes register 0 (required ethertype) and register 1
// (required protocol); it is always ready and should be used between frames.
// Reset (rst_n low, synchronous) clears both registers to 0x0800 and 6,
// empties the pipeline and restarts frame assembly at byte zero.
// While out_ready is low with a result pending, non-final bytes keep
// flowing; a final byte waits in the input register and in_ready drops.
module eth_ipv4_tcp_frame_parser #(
  parameter int MAX_FRAME_BYTES = eitp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 in_end_of_frame,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [eitp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [eitp_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [eitp_pkg::STATUS_W-1:0]        out_status,
  output logic [47:0]                          out_dest_mac,
  output logic [47:0]                          out_src_mac,
  output logic [15:0]                          out_ether_type,
  output logic [31:0]                          out_src_ip,
  output logic [31:0]                          out_dst_ip,
  output logic [7:0]                           out_ip_protocol,
  output logic [15:0]                          out_src_port,
  output logic [15:0]                          out_dst_port,
  output logic [eitp_pkg::PAY_W-1:0]           out_payload_bytes,
  output logic                                 out_crc_checked,
  output logic                                 out_crc_match
);

  logic                 in_valid_r;
  logic [7:0]           byte_r;
  logic                 eof_r;
  logic                 step;
  logic [15:0]          req_etype_r;
  logic [7:0]           req_proto_r;
  eitp_pkg::frame_sum_t sum;

  // A final byte may only advance when the output register can take it.
  assign step     = in_valid_r && (!eof_r || !out_valid || out_ready);
  assign in_ready = !in_valid_r || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_data_byte;
      eof_r  <= in_end_of_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_etype_r <= eitp_pkg::ETHERTYPE_RST;
      req_proto_r <= eitp_pkg::PROTOCOL_RST;
    end else if (cfg_valid) begin
      if (cfg_index == eitp_pkg::REG_ETHERTYPE) begin
        req_etype_r <= cfg_data[15:0];
      end else if (cfg_index == eitp_pkg::REG_PROTOCOL) begin
        req_proto_r <= cfg_data[7:0];
      end
    end
  end

  eitp_frame #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .data_byte    (byte_r),
    .end_of_frame (eof_r),
    .sum          (sum)
  );

  eitp_result u_result (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (step && eof_r),
    .sum               (sum),
    .req_ethertype     (req_etype_r),
    .req_protocol      (req_proto_r),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_dest_mac      (out_dest_mac),
    .out_src_mac       (out_src_mac),
    .out_ether_type    (out_ether_type),
    .out_src_ip        (out_src_ip),
    .out_dst_ip        (out_dst_ip),
    .out_ip_protocol   (out_ip_protocol),
    .out_src_port      (out_src_port),
    .out_dst_port      (out_dst_port),
    .out_payload_bytes (out_payload_bytes),
    .out_crc_checked   (out_crc_checked),
    .out_crc_match     (out_crc_match)
  );

endmodule

// ----- sv/eitp_frame.sv -----
module eitp_frame #(
  parameter int MAX_FRAME_BYTES = eitp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_frame,
  output eitp_pkg::frame_sum_t  sum
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      tail_r, tail_nxt;
  logic [47:0]      dmac_r, dmac_nxt;
  logic [47:0]      smac_r, smac_nxt;
  logic [15:0]      etype_r, etype_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [63:0]      ip_r, ip_nxt;
  logic [31:0]      port_r, port_nxt;
  logic [CNT_W-1:0] pay_diff;

  always_comb begin
    crc_nxt = crc_r;
    if (count_r >= CNT_W'(eitp_pkg::CRC_SKIP)) begin
      crc_nxt = eitp_pkg::crc_byte(crc_r, tail_r[31:24]);
    end
    tail_nxt = {tail_r[23:0], data_byte};

    dmac_nxt = dmac_r;
    smac_nxt = smac_r;
    etype_nxt = etype_r;
    proto_nxt = proto_r;
    ip_nxt = ip_r;
    port_nxt = port_r;
    if (count_r < CNT_W'(eitp_pkg::MAC_DST_END)) begin
      dmac_nxt = {dmac_r[39:0], data_byte};
    end else if (count_r < CNT_W'(eitp_pkg::MAC_SRC_END)) begin
      smac_nxt = {smac_r[39:0], data_byte};
    end else if (count_r < CNT_W'(eitp_pkg::ETH_LEN)) begin
      etype_nxt = {etype_r[7:0], data_byte};
    end else if (count_r == CNT_W'(eitp_pkg::PROTO_OFS)) begin
      proto_nxt = data_byte;
    end else if (count_r >= CNT_W'(eitp_pkg::IP_ADDR_OFS) &&
                 count_r < CNT_W'(eitp_pkg::IP_END)) begin
      ip_nxt = {ip_r[55:0], data_byte};
    end else if (count_r >= CNT_W'(eitp_pkg::IP_END) &&
                 count_r < CNT_W'(eitp_pkg::PORT_END)) begin
      port_nxt = {port_r[23:0], data_byte};
    end

    // The length count sticks at the limit; CRC and trailer keep running.
    count_nxt = count_r;
    if (count_r < CNT_W'(MAX_FRAME_BYTES)) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  assign pay_diff = count_nxt - CNT_W'(eitp_pkg::FULL_LEN);

  always_comb begin
    sum.dest_mac   = dmac_nxt;
    sum.src_mac    = smac_nxt;
    sum.ether_type = etype_nxt;
    sum.protocol   = proto_nxt;
    sum.ip_pair    = ip_nxt;
    sum.port_pair  = port_nxt;
    sum.ge_eth     = count_nxt >= CNT_W'(eitp_pkg::ETH_LEN);
    sum.ge_ip      = count_nxt >= CNT_W'(eitp_pkg::IP_END);
    sum.ge_tcp     = count_nxt >= CNT_W'(eitp_pkg::TCP_END);
    sum.ge_full    = count_nxt >= CNT_W'(eitp_pkg::FULL_LEN);
    sum.payload    = eitp_pkg::PAY_W'(pay_diff);
    sum.crc_equal  = crc_nxt == tail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && end_of_frame)) begin
      count_r <= '0;
      crc_r   <= eitp_pkg::CRC_INIT;
      tail_r  <= '0;
      dmac_r  <= '0;
      smac_r  <= '0;
      etype_r <= '0;
      proto_r <= '0;
      ip_r    <= '0;
      port_r  <= '0;
    end else if (step) begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      tail_r  <= tail_nxt;
      dmac_r  <= dmac_nxt;
      smac_r  <= smac_nxt;
      etype_r <= etype_nxt;
      proto_r <= proto_nxt;
      ip_r    <= ip_nxt;
      port_r  <= port_nxt;
    end
  end

endmodule

// ----- sv/eitp_result.sv -----
module eitp_result (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  eitp_pkg::frame_sum_t                 sum,
  input  logic [15:0]                          req_ethertype,
  input  logic [7:0]                           req_protocol,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [eitp_pkg::STATUS_W-1:0]        out_status,
  output logic [47:0]                          out_dest_mac,
  output logic [47:0]                          out_src_mac,
  output logic [15:0]                          out_ether_type,
  output logic [31:0]                          out_src_ip,
  output logic [31:0]                          out_dst_ip,
  output logic [7:0]                           out_ip_protocol,
  output logic [15:0]                          out_src_port,
  output logic [15:0]                          out_dst_port,
  output logic [eitp_pkg::PAY_W-1:0]           out_payload_bytes,
  output logic                                 out_crc_checked,
  output logic                                 out_crc_match
);

  logic                          valid_r;
  logic [eitp_pkg::STATUS_W-1:0] status_nxt, status_r;
  logic                          show_eth, show_ip, show_tcp, show_full;
  logic [47:0]                   dmac_r, smac_r;
  logic [15:0]                   etype_r, sport_r, dport_r;
  logic [31:0]                   sip_r, dip_r;
  logic [7:0]                    proto_r;
  logic [eitp_pkg::PAY_W-1:0]    pay_r;
  logic                          chk_r, match_r;

  // Each later header is reported only when all earlier checks passed.
  always_comb begin
    show_eth = 1'b0;
    show_ip = 1'b0;
    show_tcp = 1'b0;
    status_nxt = eitp_pkg::ST_OK;
    if (!sum.ge_eth) begin
      status_nxt = eitp_pkg::ST_SHORT_ETH;
    end else begin
      show_eth = 1'b1;
      if (sum.ether_type != req_ethertype) begin
        status_nxt = eitp_pkg::ST_BAD_ETHERTYPE;
      end else if (!sum.ge_ip) begin
        status_nxt = eitp_pkg::ST_SHORT_IP;
      end else begin
        show_ip = 1'b1;
        if (sum.protocol != req_protocol) begin
          status_nxt = eitp_pkg::ST_BAD_PROTOCOL;
        end else if (!sum.ge_tcp) begin
          status_nxt = eitp_pkg::ST_SHORT_TCP;
        end else begin
          show_tcp = 1'b1;
        end
      end
    end
    show_full = show_tcp && sum.ge_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      dmac_r   <= show_eth ? sum.dest_mac : '0;
      smac_r   <= show_eth ? sum.src_mac : '0;
      etype_r  <= show_eth ? sum.ether_type : '0;
      sip_r    <= show_ip ? sum.ip_pair[63:32] : '0;
      dip_r    <= show_ip ? sum.ip_pair[31:0] : '0;
      proto_r  <= show_ip ? sum.protocol : '0;
      sport_r  <= show_tcp ? sum.port_pair[31:16] : '0;
      dport_r  <= show_tcp ? sum.port_pair[15:0] : '0;
      pay_r    <= show_full ? sum.payload : '0;
      chk_r    <= show_full;
      match_r  <= show_full && sum.crc_equal;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_dest_mac      = dmac_r;
  assign out_src_mac       = smac_r;
  assign out_ether_type    = etype_r;
  assign out_src_ip        = sip_r;
  assign out_dst_ip        = dip_r;
  assign out_ip_protocol   = proto_r;
  assign out_src_port      = sport_r;
  assign out_dst_port      = dport_r;
  assign out_payload_bytes = pay_r;
  assign out_crc_checked   = chk_r;
  assign out_crc_match     = match_r;

endmodule

// ----- dv/eth_ipv4_tcp_frame_parser_tb.sv -----
`timescale 1ns / 1ps

module eth_ipv4_tcp_frame_parser_tb;
  import eitp_pkg::*;

  localparam int FRAME_CAP = MAX_FRAME_BYTES_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_CAP = 40;

  typedef enum logic [2:0] {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_ETYPE,
    FR_BAD_PROTO,
    FR_NOISE,
    FR_FILL_00,
    FR_FILL_FF
  } frame_kind_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [47:0]         dest_mac;
    logic [47:0]         src_mac;
    logic [15:0]         ether_type;
    logic [31:0]         src_ip;
    logic [31:0]         dst_ip;
    logic [7:0]          ip_protocol;
    logic [15:0]         src_port;
    logic [15:0]         dst_port;
    logic [PAY_W-1:0]    payload_bytes;
    logic                crc_checked;
    logic                crc_match;
  } parse_result_t;

  typedef struct packed {
    logic [15:0]         len;
    frame_kind_t         kind;
    logic                typed;
    logic [STATUS_W-1:0] exp_status;
    logic [47:0]         exp_mac;
    logic [15:0]         exp_etype;
  } directed_row_t;

  // Rows with typed set carry their result in the row; the rest go through the predictor.
  directed_row_t directed_rows [20] = '{
    '{16'd1,     FR_FILL_FF,   1'b1, ST_SHORT_ETH,     48'h0,              16'h0},
    '{16'd13,    FR_FILL_FF,   1'b1, ST_SHORT_ETH,     48'h0,              16'h0},
    '{16'd14,    FR_FILL_00,   1'b1, ST_BAD_ETHERTYPE, 48'h0,              16'h0},
    '{16'd14,    FR_FILL_FF,   1'b1, ST_BAD_ETHERTYPE, 48'hFFFF_FFFF_FFFF, 16'hFFFF},
    '{16'd70,    FR_FILL_FF,   1'b1, ST_BAD_ETHERTYPE, 48'hFFFF_FFFF_FFFF, 16'hFFFF},
    '{16'd5,     FR_GOOD,      1'b0, ST_OK,            48'h0,              16'h0},
    '{16'd14,    FR_GOOD,      1'b0, ST_OK,            48'h0,              16'h0},
    '{16'd33,    FR_GOOD,      1'b0, ST_OK,            48'h0,              16'h0},
    '{16'd34,    FR_GOOD,      1'b0, ST_OK,            48'h0,              16'h0},
    '{16'd53,    FR_GOOD,      1'b0, ST_OK,            48'h0,              16'h0},
    '{16'd54,    FR_GOOD,      1'b0, ST_OK,            48'h0,              16'h0},
    '{16'd57,    FR_GOOD,      1'b0, ST_OK,            48'h0,              16'h0},
    '{16'd58,    FR_GOOD,      1'b0, ST_OK,            48'h0,              16'h0},
    '{16'd58,    FR_BAD_CRC,   1'b0, ST_OK,            48'h0,              16'h0},
    '{16'd59,    FR_GOOD,      1'b0, ST_OK,            48'h0,              16'h0},
    '{16'd34,    FR_BAD_PROTO, 1'b0, ST_OK,            48'h0,              16'h0},
    '{16'd61,    FR_BAD_PROTO, 1'b0, ST_OK,            48'h0,              16'h0},
    '{16'd40,    FR_BAD_ETYPE, 1'b0, ST_OK,            48'h0,              16'h0},
    '{16'd64,    FR_NOISE,     1'b0, ST_OK,            48'h0,              16'h0},
    '{16'd255,   FR_GOOD,      1'b0, ST_OK,            48'h0,              16'h0}
  };

  int boundary_lens [8] = '{13, 14, 33, 34, 53, 54, 57, 58};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic in_end_of_frame = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [47:0] out_dest_mac;
  logic [47:0] out_src_mac;
  logic [15:0] out_ether_type;
  logic [31:0] out_src_ip;
  logic [31:0] out_dst_ip;
  logic [7:0] out_ip_protocol;
  logic [15:0] out_src_port;
  logic [15:0] out_dst_port;
  logic [PAY_W-1:0] out_payload_bytes;
  logic out_crc_checked;
  logic out_crc_match;

  eth_ipv4_tcp_frame_parser #(
    .MAX_FRAME_BYTES(FRAME_CAP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_end_of_frame(in_end_of_frame),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_dest_mac(out_dest_mac),
    .out_src_mac(out_src_mac),
    .out_ether_type(out_ether_type),
    .out_src_ip(out_src_ip),
    .out_dst_ip(out_dst_ip),
    .out_ip_protocol(out_ip_protocol),
    .out_src_port(out_src_port),
    .out_dst_port(out_dst_port),
    .out_payload_bytes(out_payload_bytes),
    .out_crc_checked(out_crc_checked),
    .out_crc_match(out_crc_match)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  int tx_idle_pct = 33;
  int rx_idle_pct = 85;
  int error_count = 0;
  int cycle_count = 0;
  int results_seen = 0;
  int frames_sent = 0;
  int frames_ended = 0;

  // Predictor copy of the registers and of the frame being assembled.
  logic [15:0] want_etype;
  logic [7:0] want_proto;
  int byte_count;
  logic [31:0] crc_acc;
  logic [31:0] tail_bytes;
  logic [47:0] dmac_acc;
  logic [47:0] smac_acc;
  logic [15:0] etype_acc;
  logic [7:0] proto_acc;
  logic [63:0] ip_pair_acc;
  logic [31:0] port_pair_acc;

  parse_result_t pending_results[$];
  parse_result_t typed_results[int];
  logic [7:0] frame_bytes[$];

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < PRINT_CAP) begin
      $display("ERROR: result %0d %s: got %0h, expected %0h", results_seen, what, got, want);
    end
    error_count++;
  endtask

  // Non-reflected CRC-32, shifting the byte in one bit at a time, MSB first.
  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[31] ^ b[i];
      c = {c[30:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic clear_frame_tracker();
    byte_count = 0;
    crc_acc = CRC_INIT;
    tail_bytes = '0;
    dmac_acc = '0;
    smac_acc = '0;
    etype_acc = '0;
    proto_acc = '0;
    ip_pair_acc = '0;
    port_pair_acc = '0;
  endtask

  task automatic track_frame_byte(input logic [7:0] b, input logic eof);
    int n;
    int flen;
    parse_result_t r;
    n = byte_count;
    // The CRC trails the input by four bytes so the trailer never enters it.
    if (n >= CRC_SKIP) begin
      crc_acc = crc32_step(crc_acc, tail_bytes[31:24]);
    end
    tail_bytes = {tail_bytes[23:0], b};
    if (n < MAC_DST_END) begin
      dmac_acc = {dmac_acc[39:0], b};
    end else if (n < MAC_SRC_END) begin
      smac_acc = {smac_acc[39:0], b};
    end else if (n < ETH_LEN) begin
      etype_acc = {etype_acc[7:0], b};
    end else if (n == PROTO_OFS) begin
      proto_acc = b;
    end else if (n >= IP_ADDR_OFS && n < IP_END) begin
      ip_pair_acc = {ip_pair_acc[55:0], b};
    end else if (n >= IP_END && n < PORT_END) begin
      port_pair_acc = {port_pair_acc[23:0], b};
    end
    if (n < FRAME_CAP) begin
      byte_count = n + 1;
    end
    if (eof) begin
      flen = byte_count;
      r = '0;
      if (flen < ETH_LEN) begin
        r.status = ST_SHORT_ETH;
      end else begin
        r.dest_mac = dmac_acc;
        r.src_mac = smac_acc;
        r.ether_type = etype_acc;
        if (etype_acc != want_etype) begin
          r.status = ST_BAD_ETHERTYPE;
        end else if (flen < IP_END) begin
          r.status = ST_SHORT_IP;
        end else begin
          r.src_ip = ip_pair_acc[63:32];
          r.dst_ip = ip_pair_acc[31:0];
          r.ip_protocol = proto_acc;
          if (proto_acc != want_proto) begin
            r.status = ST_BAD_PROTOCOL;
          end else if (flen < TCP_END) begin
            r.status = ST_SHORT_TCP;
          end else begin
            r.status = ST_OK;
            r.src_port = port_pair_acc[31:16];
            r.dst_port = port_pair_acc[15:0];
            if (flen >= FULL_LEN) begin
              r.payload_bytes = PAY_W'(flen - FULL_LEN);
              r.crc_checked = 1'b1;
              r.crc_match = (crc_acc == tail_bytes);
            end
          end
        end
      end
      if (typed_results.exists(frames_ended)) begin
        r = typed_results[frames_ended];
        typed_results.delete(frames_ended);
      end
      frames_ended++;
      pending_results.push_back(r);
      clear_frame_tracker();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      want_etype = ETHERTYPE_RST;
      want_proto = PROTOCOL_RST;
      clear_frame_tracker();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ETHERTYPE) begin
          want_etype = cfg_data[15:0];
        end else if (cfg_index == REG_PROTOCOL) begin
          want_proto = cfg_data[7:0];
        end
      end
      if (in_valid && in_ready) begin
        track_frame_byte(in_data_byte, in_end_of_frame);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", out_status, '0);
        end else begin
          parse_result_t w;
          w = pending_results.pop_front();
          if (out_status !== w.status)
            report_mismatch("status", out_status, w.status);
          if (out_dest_mac !== w.dest_mac)
            report_mismatch("dest_mac", out_dest_mac, w.dest_mac);
          if (out_src_mac !== w.src_mac)
            report_mismatch("src_mac", out_src_mac, w.src_mac);
          if (out_ether_type !== w.ether_type)
            report_mismatch("ether_type", out_ether_type, w.ether_type);
          if (out_src_ip !== w.src_ip)
            report_mismatch("src_ip", out_src_ip, w.src_ip);
          if (out_dst_ip !== w.dst_ip)
            report_mismatch("dst_ip", out_dst_ip, w.dst_ip);
          if (out_ip_protocol !== w.ip_protocol)
            report_mismatch("ip_protocol", out_ip_protocol, w.ip_protocol);
          if (out_src_port !== w.src_port)
            report_mismatch("src_port", out_src_port, w.src_port);
          if (out_dst_port !== w.dst_port)
            report_mismatch("dst_port", out_dst_port, w.dst_port);
          if (out_payload_bytes !== w.payload_bytes)
            report_mismatch("payload_bytes", out_payload_bytes, w.payload_bytes);
          if (out_crc_checked !== w.crc_checked)
            report_mismatch("crc_checked", out_crc_checked, w.crc_checked);
          if (out_crc_match !== w.crc_match)
            report_mismatch("crc_match", out_crc_match, w.crc_match);
        end
        results_seen++;
      end
    end
  end

  // Fills frame_bytes; header fields and trailer are fixed up according to the kind.
  task automatic build_frame(input int len, input frame_kind_t kind);
    logic [31:0] crc;
    int k;
    int pos;
    frame_bytes.delete();
    for (int i = 0; i < len; i++) begin
      case (kind)
        FR_FILL_00: frame_bytes.push_back(8'h00);
        FR_FILL_FF: frame_bytes.push_back(8'hFF);
        default:    frame_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if (kind inside {FR_GOOD, FR_BAD_CRC, FR_BAD_ETYPE, FR_BAD_PROTO}) begin
      if (len >= ETH_LEN) begin
        frame_bytes[ETH_LEN-2] = want_etype[15:8];
        frame_bytes[ETH_LEN-1] = want_etype[7:0];
        if (kind == FR_BAD_ETYPE) begin
          k = $urandom_range(0, 7);
          pos = ETH_LEN - 2 + $urandom_range(0, 1);
          frame_bytes[pos][k] ^= 1'b1;
        end
      end
      if (len > PROTO_OFS) begin
        frame_bytes[PROTO_OFS] = want_proto;
        if (kind == FR_BAD_PROTO) begin
          k = $urandom_range(0, 7);
          frame_bytes[PROTO_OFS][k] ^= 1'b1;
        end
      end
      if (len >= FULL_LEN) begin
        crc = CRC_INIT;
        for (int i = 0; i < len - CRC_SKIP; i++) begin
          crc = crc32_step(crc, frame_bytes[i]);
        end
        if (kind == FR_BAD_CRC) begin
          k = $urandom_range(0, 31);
          crc[k] = ~crc[k];
        end
        frame_bytes[len-4] = crc[31:24];
        frame_bytes[len-3] = crc[23:16];
        frame_bytes[len-2] = crc[15:8];
        frame_bytes[len-1] = crc[7:0];
      end
    end
  endtask

  // Presents one byte request and holds it until the parser takes it.
  task automatic push_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_frame <= eof;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_frame(input logic has_typed, input parse_result_t typed);
    if (has_typed) begin
      typed_results[frames_sent] = typed;
    end
    frames_sent++;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // The first edge lets the monitor see a byte taken in this step before the queue is read.
  task automatic wait_idle();
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int flen;
    int pick;
    int seg_bytes;
    int seg_frames;
    frame_kind_t kind;
    logic [15:0] new_etype;
    logic [7:0] new_proto;
    parse_result_t typed;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      build_frame(directed_rows[i].len, directed_rows[i].kind);
      typed = '0;
      typed.status = directed_rows[i].exp_status;
      typed.dest_mac = directed_rows[i].exp_mac;
      typed.src_mac = directed_rows[i].exp_mac;
      typed.ether_type = directed_rows[i].exp_etype;
      send_frame(directed_rows[i].typed, typed);
    end
    in_valid <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 33; rx_idle_pct = 85; end
        1: begin tx_idle_pct = 85; rx_idle_pct = 33; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        case ((phase * 3 + seg) % 4)
          0: begin new_etype = 16'h0000; new_proto = 8'h00; end
          1: begin new_etype = 16'hFFFF; new_proto = 8'hFF; end
          2: begin new_etype = ETHERTYPE_RST; new_proto = PROTOCOL_RST; end
          default: begin new_etype = 16'($urandom); new_proto = 8'($urandom); end
        endcase
        wait_idle();
        // An index past the register list must leave both registers alone.
        write_reg(8'($urandom_range(2, 255)), 16'($urandom));
        write_reg(REG_ETHERTYPE, new_etype);
        write_reg(REG_PROTOCOL, {8'($urandom), new_proto});
        cfg_valid <= 1'b0;
        // The monitor takes the last write at that edge; frames are built after it.
        @(posedge clk);

        seg_bytes = 0;
        seg_frames = 0;
        while (seg_bytes < 70 || seg_frames < 4) begin
          pick = $urandom_range(0, 99);
          if (pick < 15) flen = boundary_lens[$urandom_range(0, 7)];
          else if (pick < 25) flen = $urandom_range(1, 13);
          else if (pick < 40) flen = $urandom_range(14, 57);
          else if (pick < 85) flen = $urandom_range(58, 64);
          else if (pick < 98) flen = $urandom_range(65, 120);
          else flen = $urandom_range(121, 300);
          pick = $urandom_range(0, 99);
          if (pick < 55) kind = FR_GOOD;
          else if (pick < 67) kind = FR_BAD_CRC;
          else if (pick < 77) kind = FR_BAD_ETYPE;
          else if (pick < 87) kind = FR_BAD_PROTO;
          else if (pick < 93) kind = FR_NOISE;
          else if (pick < 97) kind = FR_FILL_00;
          else kind = FR_FILL_FF;
          build_frame(flen, kind);
          send_frame(1'b0, '0);
          seg_bytes += flen;
          seg_frames++;
        end
        in_valid <= 1'b0;
      end
    end

    wait_idle();
    if (pending_results.size() != 0) begin
      report_mismatch("results never produced, count", pending_results.size(), '0);
    end
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/eitp_pkg.sv
sv/eitp_frame.sv
sv/eitp_result.sv
sv/eth_ipv4_tcp_frame_parser.sv
dv/eth_ipv4_tcp_frame_parser_tb.sv
